>>> hdl/mm3h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3h_pkg
// Shared constants, controller states, command and status types and small
// helper functions for the 32-bit murmur3 stream hash unit.
// ----------------------------------------------------------------------------
package mm3h_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    localparam logic [2:0] FULL_COUNT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDLE_UPD,
        ST_MIX,
        ST_UPD,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mix;
        logic upd;
        logic fin1;
        logic fin2;
        logic fin3;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } dp_status_t;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        rotl15 = {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        rotl13 = {v[18:0], v[31:19]};
    endfunction

    function automatic logic [2:0] sat_count(input logic [2:0] c);
        sat_count = (c > FULL_COUNT) ? FULL_COUNT : c;
    endfunction

    function automatic logic [31:0] byte_mask(input logic [2:0] c);
        case (c)
            3'd0:    byte_mask = 32'h0000_0000;
            3'd1:    byte_mask = 32'h0000_00ff;
            3'd2:    byte_mask = 32'h0000_ffff;
            3'd3:    byte_mask = 32'h00ff_ffff;
            default: byte_mask = 32'hffff_ffff;
        endcase
    endfunction

endpackage

>>> hdl/mm3h_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3h_ctrl
// Sequencer for the hash datapath: word intake, scramble, hash update and
// the three finalizer steps.
// ----------------------------------------------------------------------------
module mm3h_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mm3h_pkg::dp_status_t status,
    output mm3h_pkg::dp_cmd_t    cmd
);

    mm3h_pkg::ctrl_state_t state_reg;
    mm3h_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mm3h_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mm3h_pkg::ST_IDLE, mm3h_pkg::ST_IDLE_UPD: begin
                state_next = s_valid ? mm3h_pkg::ST_MIX : mm3h_pkg::ST_IDLE;
            end
            mm3h_pkg::ST_MIX: begin
                state_next = status.last ? mm3h_pkg::ST_UPD : mm3h_pkg::ST_IDLE_UPD;
            end
            mm3h_pkg::ST_UPD:  state_next = mm3h_pkg::ST_FIN1;
            mm3h_pkg::ST_FIN1: state_next = mm3h_pkg::ST_FIN2;
            mm3h_pkg::ST_FIN2: state_next = mm3h_pkg::ST_FIN3;
            mm3h_pkg::ST_FIN3: begin
                if (!status.out_busy) begin
                    state_next = mm3h_pkg::ST_IDLE;
                end
            end
            default: state_next = mm3h_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            mm3h_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            mm3h_pkg::ST_IDLE_UPD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                cmd.upd  = 1'b1;
            end
            mm3h_pkg::ST_MIX:  cmd.mix  = 1'b1;
            mm3h_pkg::ST_UPD:  cmd.upd  = 1'b1;
            mm3h_pkg::ST_FIN1: cmd.fin1 = 1'b1;
            mm3h_pkg::ST_FIN2: cmd.fin2 = 1'b1;
            mm3h_pkg::ST_FIN3: cmd.fin3 = !status.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

>>> hdl/mm3h_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3h_dp
// Hash datapath: one shared 32x32 constant multiplier, running hash, byte
// total, message flag and the result register.
// ----------------------------------------------------------------------------
module mm3h_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          hash_seed_wdata,
    input  logic                 hash_seed_we,
    input  logic [31:0]          data_word,
    input  logic [2:0]           valid_bytes,
    input  logic                 last_word,
    input  mm3h_pkg::dp_cmd_t    cmd,
    output mm3h_pkg::dp_status_t status,
    output logic [31:0]          hash_value,
    output logic                 out_valid,
    input  logic                 out_ready
);

    logic [31:0] seed_reg;
    logic [31:0] hash_reg,  hash_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] work_reg,  work_next;
    logic [2:0]  count_reg;
    logic        last_reg;
    logic        in_msg_reg, in_msg_next;
    logic [31:0] res_reg,   res_next;
    logic        ovalid_reg, ovalid_next;

    logic [2:0]  count_sat;
    logic [31:0] fin_x;
    logic [31:0] mul_a, mul_k, product;
    logic [31:0] mixed, rot;
    logic [31:0] base_hash;

    assign count_sat = mm3h_pkg::sat_count(valid_bytes);
    assign fin_x     = hash_reg ^ total_reg;

    always_comb begin
        mul_a = work_reg ^ {13'd0, work_reg[31:13]};
        mul_k = mm3h_pkg::FIN_M2;
        if (cmd.load) begin
            mul_a = data_word & mm3h_pkg::byte_mask(count_sat);
            mul_k = mm3h_pkg::MIX_C1;
        end else if (cmd.mix) begin
            mul_a = mm3h_pkg::rotl15(work_reg);
            mul_k = mm3h_pkg::MIX_C2;
        end else if (cmd.fin1) begin
            mul_a = fin_x ^ {16'd0, fin_x[31:16]};
            mul_k = mm3h_pkg::FIN_M1;
        end
    end

    assign product = mul_a * mul_k;

    assign mixed = hash_reg ^ work_reg;
    assign rot   = mm3h_pkg::rotl13(mixed);

    always_comb begin
        base_hash = hash_reg;
        if (cmd.upd) begin
            if (count_reg == mm3h_pkg::FULL_COUNT) begin
                base_hash = {rot[29:0], 2'b00} + rot + mm3h_pkg::MIX_ADD;
            end else begin
                base_hash = mixed;
            end
        end
    end

    always_comb begin
        hash_next   = base_hash;
        total_next  = total_reg;
        in_msg_next = in_msg_reg;
        work_next   = work_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && out_ready) begin
            ovalid_next = 1'b0;
        end
        if (cmd.load) begin
            in_msg_next = 1'b1;
            if (!in_msg_reg) begin
                hash_next  = seed_reg;
                total_next = {29'd0, count_sat};
            end else begin
                total_next = total_reg + {29'd0, count_sat};
            end
        end
        if (cmd.load || cmd.mix || cmd.fin1 || cmd.fin2) begin
            work_next = product;
        end
        if (cmd.fin1) begin
            in_msg_next = 1'b0;
        end
        if (cmd.fin3) begin
            res_next    = (total_reg == 32'd0) ? 32'd0
                                               : (work_reg ^ {16'd0, work_reg[31:16]});
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= 32'd0;
            in_msg_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            if (hash_seed_we) begin
                seed_reg <= hash_seed_wdata;
            end
            in_msg_reg <= in_msg_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg  <= hash_next;
        total_reg <= total_next;
        work_reg  <= work_next;
        res_reg   <= res_next;
        if (cmd.load) begin
            count_reg <= count_sat;
            last_reg  <= last_word;
        end
    end

    assign status.last     = last_reg;
    assign status.out_busy = ovalid_reg && !out_ready;
    assign hash_value      = res_reg;
    assign out_valid       = ovalid_reg;

endmodule

>>> hdl/murmur3_32_hash_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_32_hash_stream_unit
// 32-bit murmur3 hash over a message streamed as little-endian words.
//
// Usage:
//   Write the seed through hash_seed_we / hash_seed_wdata while idle; reset
//   sets it to zero. Send the message on s_axis_*: tdata[31:0] holds four
//   bytes, first byte in bits 7:0, tdata[34:32] the count of valid bytes
//   (5 to 7 count as 4), and tlast marks the final word. One hash word per
//   message comes out on m_axis_tdata after the last word.
//   A non-last word takes the intake multiply, then the second scramble
//   multiply; the next word is taken only then, its intake overlapping the
//   hash update. A last word adds the hash update and finalizer steps, the
//   single shared multiplier running the scramble and the two finalizer
//   multiplies in turn; the final step loads the output register.
//   The output register lets the next message start while a result waits;
//   if the receiver stalls with a result pending, the next last word holds
//   in its final step until the register frees.
//   Reset clears the seed, the message state and the output valid.
// ----------------------------------------------------------------------------
module murmur3_32_hash_stream_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        hash_seed_we,
    input  logic [31:0] hash_seed_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_word[31:0], valid_bytes[34:32], zero pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // hash_value[31:0]
);

    mm3h_pkg::dp_cmd_t    cmd;
    mm3h_pkg::dp_status_t status;

    mm3h_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    mm3h_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .hash_seed_wdata (hash_seed_wdata),
        .hash_seed_we    (hash_seed_we),
        .data_word       (s_axis_tdata[31:0]),
        .valid_bytes     (s_axis_tdata[34:32]),
        .last_word       (s_axis_tlast),
        .cmd             (cmd),
        .status          (status),
        .hash_value      (m_axis_tdata),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test for murmur3_32_hash_stream_unit. A driver sends message words
// from a queue and predicts the 32-bit murmur3 hash of each finished message.
// A monitor compares every hash word that leaves the block with the oldest
// prediction. The run starts with directed corner cases: empty messages,
// partial and oversized byte counts, zero-count and partial words inside a
// message. It then sends random messages under several seeds, with random
// gaps and stalls on both sides, one long output stall and a quiet tail.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 200;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } msg_word_t;

    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        hash_seed_we    = 1'b0;
    logic [31:0] hash_seed_wdata = '0;
    logic        s_axis_tvalid   = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata    = '0;   // data_word[31:0], valid_bytes[34:32], zero pad
    logic        s_axis_tlast    = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready   = 1'b0;
    logic [31:0] m_axis_tdata;           // hash_value[31:0]

    msg_word_t   pending_words[$];
    msg_word_t   held_word;
    logic [31:0] expected_hashes[$];

    // predictor state
    logic [31:0] seed_copy = '0;
    logic [31:0] msg_hash  = '0;
    logic [31:0] msg_bytes = '0;
    logic        msg_open  = 1'b0;

    bit          idle_on = 1'b1;
    int          long_stall_reqs = 0;
    int          words_queued = 0;
    int          messages_queued = 0;
    int          seeds_used = 1;
    int          hashes_checked = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    murmur3_32_hash_stream_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .hash_seed_we    (hash_seed_we),
        .hash_seed_wdata (hash_seed_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] scramble_block(input logic [31:0] k);
        logic [31:0] t;
        t = k * mm3h_pkg::MIX_C1;
        t = (t << 15) | (t >> 17);
        return t * mm3h_pkg::MIX_C2;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * mm3h_pkg::FIN_M1;
        t = t ^ (t >> 13);
        t = t * mm3h_pkg::FIN_M2;
        return t ^ (t >> 16);
    endfunction

    // Fold one accepted word into the predicted message state; a last word
    // yields the finished hash.
    function automatic bit absorb_word(input msg_word_t w, output logic [31:0] digest);
        logic [2:0]  n;
        logic [31:0] h;
        n = (w.nbytes > mm3h_pkg::FULL_COUNT) ? mm3h_pkg::FULL_COUNT : w.nbytes;
        if (!msg_open) begin
            msg_hash  = seed_copy;
            msg_bytes = '0;
            msg_open  = 1'b1;
        end
        if (n == mm3h_pkg::FULL_COUNT) begin
            h = msg_hash ^ scramble_block(w.data);
            h = (h << 13) | (h >> 19);
            msg_hash = h * 32'd5 + mm3h_pkg::MIX_ADD;
        end else if (n != 3'd0) begin
            msg_hash = msg_hash ^ scramble_block(w.data & ((32'd1 << (8 * n)) - 32'd1));
        end
        msg_bytes = msg_bytes + 32'(n);
        digest = '0;
        if (!w.last) begin
            return 1'b0;
        end
        msg_open = 1'b0;
        digest = (msg_bytes == 0) ? 32'd0 : avalanche(msg_hash ^ msg_bytes);
        return 1'b1;
    endfunction

    // driver
    int src_gap = 0;
    always @(posedge aclk) begin
        logic [31:0] digest;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (absorb_word(held_word, digest)) begin
                    expected_hashes.push_back(digest);
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap = src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 4);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    held_word = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'd0, held_word.nbytes, held_word.data};
                    s_axis_tlast  <= held_word.last;
                end
            end
        end
    end

    // monitor and receiver stalls
    int sink_gap = 0;
    int long_stall_left = 0;
    int long_stall_taken = 0;
    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_hashes.size() == 0) begin
                    $error("hash_value: no hash expected, got %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_hashes.pop_front();
                    hashes_checked++;
                    if (m_axis_tdata !== want) begin
                        $error("hash_value: expected %h, actual %h", want, m_axis_tdata);
                        mismatches++;
                    end
                end
            end
            if (long_stall_left > 0) begin
                long_stall_left = long_stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if (long_stall_taken != long_stall_reqs) begin
                long_stall_taken++;
                long_stall_left = LONG_STALL - 1;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap = sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("murmur3_32_hash_stream_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_word(input logic [31:0] d, input logic [2:0] n, input logic l);
        msg_word_t w;
        w.data   = d;
        w.nbytes = n;
        w.last   = l;
        pending_words.push_back(w);
        words_queued++;
        if (l) begin
            messages_queued++;
        end
    endtask

    task automatic add_random_message(input int max_words);
        int nw;
        nw = $urandom_range(1, max_words);
        for (int i = 0; i < nw - 1; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                add_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
            end else begin
                add_word($urandom, mm3h_pkg::FULL_COUNT, 1'b0);
            end
        end
        add_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    task automatic fill_messages(input int nwords, input int max_words);
        int stop;
        stop = words_queued + nwords;
        while (words_queued < stop) begin
            add_random_message(max_words);
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_hashes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        @(posedge aclk);
        hash_seed_we    <= 1'b1;
        hash_seed_wdata <= v;
        seed_copy = v;
        seeds_used++;
        @(posedge aclk);
        hash_seed_we    <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner cases under the reset seed
        add_word($urandom, 3'd0, 1'b1);
        add_word(32'h0000_0000, 3'd0, 1'b0);
        add_word($urandom, 3'd0, 1'b1);
        add_word(32'hffff_ffff, mm3h_pkg::FULL_COUNT, 1'b1);
        add_word(32'h0000_0000, mm3h_pkg::FULL_COUNT, 1'b0);
        add_word(32'hffff_ffff, 3'd1, 1'b1);
        add_word($urandom, 3'd2, 1'b1);
        add_word($urandom, 3'd3, 1'b1);
        add_word($urandom, 3'd5, 1'b0);
        add_word($urandom, 3'd6, 1'b0);
        add_word($urandom, 3'd7, 1'b1);
        add_word($urandom, 3'd0, 1'b0);
        add_word($urandom, mm3h_pkg::FULL_COUNT, 1'b0);
        add_word($urandom, 3'd2, 1'b0);
        add_word($urandom, mm3h_pkg::FULL_COUNT, 1'b1);
        add_word(32'h8000_0000, mm3h_pkg::FULL_COUNT, 1'b0);
        add_word(32'h0000_0001, 3'd3, 1'b1);
        wait_drained();

        // short messages against a long output stall
        write_seed(32'hffff_ffff);
        long_stall_reqs++;
        fill_messages(100, 3);
        wait_drained();

        write_seed($urandom);
        fill_messages(100, 8);
        wait_drained();

        write_seed(32'h0000_0000);
        fill_messages(100, 5);
        wait_drained();

        // quiet tail: no idling on either side
        idle_on = 1'b0;
        write_seed($urandom);
        fill_messages(80, 6);
        wait_drained();

        $display("Sent %0d messages in %0d words under %0d seed settings.",
                 messages_queued, words_queued, seeds_used);
        $display("Checked %0d hash words, %0d mismatches.", hashes_checked, mismatches);
        if (mismatches == 0 && expected_hashes.size() == 0) begin
            $display("murmur3_32_hash_stream_unit test passed");
        end else begin
            $display("murmur3_32_hash_stream_unit test failed");
        end
        $finish;
    end

endmodule
